// ===== rtl/mcos_pkg.sv =====
`timescale 1ns / 1ps
package mcos_pkg;

	// field widths
	localparam int CMD_W  = 2;
	localparam int SLOT_W = 2;
	localparam int MS_W   = 32;
	localparam int SUB_W  = 14;
	localparam int MASK_W = 4;

	// sub_count * 1000 stays below 2^24 for any 14-bit sub_count
	localparam int NUM_W = 24;

	localparam int US_PER_MS = 1000;

	// parameter defaults
	localparam int SLOTS_DEF           = 4;
	localparam int SUB_TICKS_PER_MS_DEF = 16000;

	typedef enum logic [CMD_W-1:0] {
		CMD_TICK = 2'd0,
		CMD_ARM  = 2'd1,
		CMD_READ = 2'd2
	} cmd_t;

	// one item as it leaves the input stage
	typedef struct packed {
		logic              fire;
		cmd_t              cmd;
		logic [SLOT_W-1:0] slot;
		logic [MS_W-1:0]   period;
	} step_t;

endpackage

// ===== rtl/millisecond_clock_with_oneshot_slots_unit.sv =====
`timescale 1ns / 1ps
// Millisecond clock with one-shot countdown slots.
// Command channel (cmd_valid / cmd_stall): one beat per command, tick, arm
// or read. A tick advances the millisecond count and counts down every armed
// slot; an arm loads a slot's period; a read samples the time in microseconds
// from the count and sub_count. Command 3 changes nothing.
// Result channel (rsp_valid / rsp_stall): exactly one beat per command, in
// order, carrying the expiry mask, the millisecond count after the command
// and the microsecond time.
// A result passes through the input register, then the result register,
// before it is offered. Throughput: one command per cycle while the receiver
// does not stall, set by the single stage of slot and counter update logic
// between the two registers.
// When the receiver stalls, the held result stays put; one more command can
// sit in the input register, after which cmd_stall rises in the same cycle.
// Reset clears the count, disarms all slots and empties both registers.
module millisecond_clock_with_oneshot_slots_unit #(
	parameter int SLOTS            = mcos_pkg::SLOTS_DEF,
	parameter int SUB_TICKS_PER_MS = mcos_pkg::SUB_TICKS_PER_MS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cmd_valid,
	output logic                        cmd_stall,
	input  logic [mcos_pkg::CMD_W-1:0]  command,
	input  logic [mcos_pkg::SLOT_W-1:0] slot,
	input  logic [mcos_pkg::MS_W-1:0]   period,
	input  logic [mcos_pkg::SUB_W-1:0]  sub_count,
	output logic                        rsp_valid,
	input  logic                        rsp_stall,
	output logic [mcos_pkg::MASK_W-1:0] expired_mask,
	output logic [mcos_pkg::MS_W-1:0]   millis,
	output logic [mcos_pkg::MS_W-1:0]   micros
);
	import mcos_pkg::*;

	logic              valid_s1;
	cmd_t              cmd_s1;
	logic [SLOT_W-1:0] slot_s1;
	logic [MS_W-1:0]   period_s1;
	logic [NUM_W-1:0]  num_s1;

	logic              rsp_valid_q;
	logic [MASK_W-1:0] mask_q;
	logic [MS_W-1:0]   millis_q;
	logic [MS_W-1:0]   micros_q;

	logic              take;
	logic              adv;
	step_t             step;
	logic [MASK_W-1:0] mask_next;
	logic [MS_W-1:0]   millis_next;
	logic [MS_W-1:0]   micros_next;

	// handshake
	assign adv       = valid_s1 && (!rsp_valid_q || !rsp_stall);
	assign cmd_stall = valid_s1 && !adv;
	assign take      = cmd_valid && !cmd_stall;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cmd_s1    <= cmd_t'(command);
			slot_s1   <= slot;
			period_s1 <= period;
			num_s1    <= NUM_W'(NUM_W'(sub_count) * NUM_W'(US_PER_MS));
		end
	end

	assign step.fire   = adv;
	assign step.cmd    = cmd_s1;
	assign step.slot   = slot_s1;
	assign step.period = period_s1;

	mcos_slots #(
		.SLOTS(SLOTS)
	) u_slots (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (step),
		.expired_mask(mask_next)
	);

	mcos_time #(
		.SUB_TICKS_PER_MS(SUB_TICKS_PER_MS)
	) u_time (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.num        (num_s1),
		.millis_next(millis_next),
		.micros_next(micros_next)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (adv) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mask_q   <= mask_next;
			millis_q <= millis_next;
			micros_q <= micros_next;
		end
	end

	assign rsp_valid    = rsp_valid_q;
	assign expired_mask = mask_q;
	assign millis       = millis_q;
	assign micros       = micros_q;

`ifndef SYNTH
	// input side only backs up behind a held result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_stall |-> (valid_s1 && rsp_valid_q && rsp_stall))
		else $error("cmd_stall without a held result");

	// only a tick can report expiries
	a_mask_tick: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && (cmd_s1 != CMD_TICK)) |=> (expired_mask == '0))
		else $error("expiry mask set outside a tick");

	// only a read carries a time in microseconds
	a_micros_read: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && (cmd_s1 != CMD_READ)) |=> (micros == '0))
		else $error("micros set outside a read");

	// a tick result matches the counter's next value
	a_tick_count: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && (cmd_s1 == CMD_TICK)) |=> (millis == $past(millis_next)))
		else $error("tick result does not match the counter");
`endif

endmodule

// ===== rtl/mcos_slots.sv =====
`timescale 1ns / 1ps
module mcos_slots #(
	parameter int SLOTS = mcos_pkg::SLOTS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  mcos_pkg::step_t             step,
	output logic [mcos_pkg::MASK_W-1:0] expired_mask
);
	import mcos_pkg::*;

	logic [MS_W-1:0] remaining_q [SLOTS];
	logic [SLOTS-1:0] armed_q;
	logic [SLOTS-1:0] expired;
	logic             is_tick;
	logic             is_arm;

	assign is_tick = (step.cmd == CMD_TICK);
	assign is_arm  = (step.cmd == CMD_ARM);

	// a slot expires when its count steps from one to zero
	always_comb begin
		for (int i = 0; i < SLOTS; i++) begin
			expired[i] = is_tick && armed_q[i] && (remaining_q[i] == MS_W'(1));
		end
	end

	// only the first four slots show in the mask
	always_comb begin
		expired_mask = '0;
		for (int j = 0; j < MASK_W; j++) begin
			if (j < SLOTS) begin
				expired_mask[j] = expired[j % SLOTS];
			end
		end
	end

	// armed flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q <= '0;
		end else if (step.fire) begin
			for (int i = 0; i < SLOTS; i++) begin
				if (is_tick && expired[i]) begin
					armed_q[i] <= 1'b0;
				end else if (is_arm && (6'(step.slot) == 6'(i))) begin
					armed_q[i] <= 1'b1;
				end
			end
		end
	end

	// remaining counts, zero period wraps on the first tick
	always_ff @(posedge clk) begin
		if (step.fire) begin
			for (int i = 0; i < SLOTS; i++) begin
				if (is_tick && armed_q[i]) begin
					remaining_q[i] <= remaining_q[i] - MS_W'(1);
				end else if (is_arm && (6'(step.slot) == 6'(i))) begin
					remaining_q[i] <= step.period;
				end
			end
		end
	end

endmodule

// ===== rtl/mcos_time.sv =====
`timescale 1ns / 1ps
module mcos_time #(
	parameter int SUB_TICKS_PER_MS = mcos_pkg::SUB_TICKS_PER_MS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  mcos_pkg::step_t            step,
	input  logic [mcos_pkg::NUM_W-1:0] num,
	output logic [mcos_pkg::MS_W-1:0]  millis_next,
	output logic [mcos_pkg::MS_W-1:0]  micros_next
);
	import mcos_pkg::*;

	// floor(num / SUB_TICKS_PER_MS) by a rounded-up reciprocal, exact for NUM_W-bit num
	localparam int SHIFT   = NUM_W + $clog2(SUB_TICKS_PER_MS);
	localparam int RECIP_W = NUM_W + 1;
	localparam int PROD_W  = NUM_W + RECIP_W;
	localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(((64'd1 << SHIFT)
		+ 64'(SUB_TICKS_PER_MS) - 64'd1) / 64'(SUB_TICKS_PER_MS));

	logic [MS_W-1:0]   ms_q;
	logic [PROD_W-1:0] prod;
	logic [PROD_W-1:0] quot;
	logic [NUM_W-1:0]  frac;
	logic [MS_W-1:0]   ms_us;

	// millisecond counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ms_q <= '0;
		end else if (step.fire && (step.cmd == CMD_TICK)) begin
			ms_q <= ms_q + MS_W'(1);
		end
	end

	assign millis_next = (step.cmd == CMD_TICK) ? ms_q + MS_W'(1) : ms_q;

	// microsecond time for a read
	assign prod  = PROD_W'(num) * PROD_W'(RECIP);
	assign quot  = prod >> SHIFT;
	assign frac  = quot[NUM_W-1:0];
	assign ms_us = MS_W'(ms_q * MS_W'(US_PER_MS));

	assign micros_next = (step.cmd == CMD_READ) ? ms_us + MS_W'(frac) : '0;

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
	import mcos_pkg::*;

	// command code that the block must treat as a no-op
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 200000;

	typedef struct {
		logic [MASK_W-1:0] mask;
		logic [MS_W-1:0]   ms;
		logic [MS_W-1:0]   us;
	} time_beat_t;

	logic              clk;
	logic              arst_n;
	logic              cmd_valid;
	logic              cmd_stall;
	logic [CMD_W-1:0]  command;
	logic [SLOT_W-1:0] slot;
	logic [MS_W-1:0]   period;
	logic [SUB_W-1:0]  sub_count;
	logic              rsp_valid;
	logic              rsp_stall;
	logic [MASK_W-1:0] expired_mask;
	logic [MS_W-1:0]   millis;
	logic [MS_W-1:0]   micros;

	// predicted clock and slot state
	logic [MS_W-1:0] ms_now = '0;
	logic [MS_W-1:0] slot_left [SLOTS_DEF] = '{default: '0};
	logic            slot_live [SLOTS_DEF] = '{default: 1'b0};
	time_beat_t      pending_times [$];

	int err_cnt   = 0;
	int cycle_cnt = 0;
	bit gaps_on   = 1'b1;
	bit stalls_on = 1'b1;
	int hold_req  = 0;

	millisecond_clock_with_oneshot_slots_unit u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (cmd_valid),
		.cmd_stall    (cmd_stall),
		.command      (command),
		.slot         (slot),
		.period       (period),
		.sub_count    (sub_count),
		.rsp_valid    (rsp_valid),
		.rsp_stall    (rsp_stall),
		.expired_mask (expired_mask),
		.millis       (millis),
		.micros       (micros)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// run guard
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// apply one accepted command to the predicted state, return the expected beat
	function automatic time_beat_t advance_clock(input logic [CMD_W-1:0] cmd,
			input logic [SLOT_W-1:0] sl, input logic [MS_W-1:0] per,
			input logic [SUB_W-1:0] sub);
		time_beat_t b;
		longint unsigned frac;
		longint unsigned whole;
		b.mask = '0;
		b.us   = '0;
		if (cmd == CMD_TICK) begin
			ms_now = ms_now + 1'b1;
			for (int i = 0; i < SLOTS_DEF; i++) begin
				if (slot_live[i]) begin
					// a zero period wraps to all ones here
					slot_left[i] = slot_left[i] - 1'b1;
					if (slot_left[i] == '0) begin
						slot_live[i] = 1'b0;
						if (i < MASK_W)
							b.mask[i] = 1'b1;
					end
				end
			end
		end else if (cmd == CMD_ARM) begin
			if (sl < SLOTS_DEF) begin
				slot_left[sl] = per;
				slot_live[sl] = 1'b1;
			end
		end else if (cmd == CMD_READ) begin
			frac  = (64'(sub) * US_PER_MS) / SUB_TICKS_PER_MS_DEF;
			whole = 64'(ms_now) * US_PER_MS;
			b.us  = 32'(whole + frac);
		end
		b.ms = ms_now;
		return b;
	endfunction

	task automatic check_field(input string name, input logic [MS_W-1:0] want_v,
			input logic [MS_W-1:0] got_v);
		if (want_v !== got_v) begin
			err_cnt++;
			$display("%0t: %s mismatch, expected %h, got %h", $time, name, want_v, got_v);
		end
	endtask

	// predict on every accepted command beat, check every accepted result beat
	always @(posedge clk) begin
		time_beat_t want;
		if (arst_n) begin
			if (cmd_valid && !cmd_stall)
				pending_times.push_back(advance_clock(command, slot, period, sub_count));
			if (rsp_valid && !rsp_stall) begin
				if (pending_times.size() == 0) begin
					err_cnt++;
					$display("%0t: unexpected result beat, expected none, got mask %h millis %h micros %h",
						$time, expired_mask, millis, micros);
				end else begin
					want = pending_times.pop_front();
					check_field("expired_mask", MS_W'(want.mask), MS_W'(expired_mask));
					check_field("millis", want.ms, millis);
					check_field("micros", want.us, micros);
				end
			end
		end
	end

	// result side: random stall per beat, or a long hold-off on request
	initial begin
		int n;
		forever begin
			if (hold_req > 0) begin
				n = hold_req;
				hold_req = 0;
			end else begin
				n = stalls_on ? $urandom_range(0, 13) : 0;
			end
			if (n > 0) begin
				rsp_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			rsp_stall <= 1'b0;
			do @(posedge clk); while (!rsp_valid);
		end
	end

	// offer one command beat and wait until it is taken
	task automatic send_beat(input logic [CMD_W-1:0] cmd, input logic [SLOT_W-1:0] sl,
			input logic [MS_W-1:0] per, input logic [SUB_W-1:0] sub);
		int gap;
		gap = gaps_on ? $urandom_range(0, 13) : 0;
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_valid <= 1'b1;
		command   <= cmd;
		slot      <= sl;
		period    <= per;
		sub_count <= sub;
		do @(posedge clk); while (cmd_stall);
	endtask

	// mostly short countdowns so slots expire often, plus noise in unused fields
	task automatic send_random_beat();
		logic [CMD_W-1:0] cmd;
		logic [MS_W-1:0]  per;
		logic [SUB_W-1:0] sub;
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 45)
			cmd = CMD_TICK;
		else if (pick < 70)
			cmd = CMD_ARM;
		else if (pick < 92)
			cmd = CMD_READ;
		else
			cmd = CMD_UNUSED;
		pick = $urandom_range(0, 99);
		if (pick < 88)
			per = $urandom_range(1, 20);
		else if (pick < 91)
			per = '0;
		else
			per = $urandom();
		if ($urandom_range(0, 1))
			sub = SUB_W'($urandom_range(0, 15999));
		else
			sub = SUB_W'($urandom_range(0, 16383));
		send_beat(cmd, SLOT_W'($urandom_range(0, 3)), per, sub);
	endtask

	task automatic wait_results_done();
		cmd_valid <= 1'b0;
		while (pending_times.size() != 0)
			@(posedge clk);
	endtask

	// reads right after reset, sub count edges, unused command
	task automatic test_reads_and_unused();
		send_beat(CMD_READ, 2'd0, '0, 14'd0);
		send_beat(CMD_READ, 2'd1, '1, 14'd15999);
		send_beat(CMD_READ, 2'd2, '0, 14'd16000);
		send_beat(CMD_READ, 2'd3, '1, 14'd16383);
		send_beat(CMD_READ, 2'd0, '0, 14'd16);
		send_beat(CMD_UNUSED, 2'd3, '1, 14'd16383);
	endtask

	// expiry, simultaneous expiry, re-arm and zero period wrap
	task automatic test_slot_expiry();
		send_beat(CMD_ARM, 2'd0, 32'd1, '0);
		send_beat(CMD_ARM, 2'd1, 32'd2, '0);
		send_beat(CMD_ARM, 2'd2, 32'd1, '0);
		send_beat(CMD_ARM, 2'd3, 32'hFFFF_FFFF, '0);
		send_beat(CMD_TICK, 2'd0, '0, '0);
		send_beat(CMD_TICK, 2'd0, '0, '0);
		send_beat(CMD_ARM, 2'd3, 32'd0, '0);
		send_beat(CMD_TICK, 2'd0, '0, '0);
		send_beat(CMD_READ, 2'd0, '0, 14'd8000);
		send_beat(CMD_ARM, 2'd1, 32'd3, '0);
		send_beat(CMD_ARM, 2'd1, 32'd1, '0);
		send_beat(CMD_TICK, 2'd0, '0, '0);
		for (int i = 0; i < SLOTS_DEF; i++)
			send_beat(CMD_ARM, SLOT_W'(i), 32'd1, '0);
		send_beat(CMD_TICK, 2'd0, '0, '0);
		send_beat(CMD_TICK, 2'd0, '0, '0);
		send_beat(CMD_READ, 2'd0, '0, 14'd16383);
	endtask

	// random traffic with idling on both sides
	task automatic test_random_idling(input int count);
		gaps_on   = 1'b1;
		stalls_on = 1'b1;
		repeat (count) send_random_beat();
	endtask

	// back-to-back beats, no stalls
	task automatic test_random_streaming(input int count);
		gaps_on   = 1'b0;
		stalls_on = 1'b0;
		repeat (count) send_random_beat();
	endtask

	// result side holds off while commands keep coming
	task automatic test_backpressure();
		gaps_on   = 1'b0;
		stalls_on = 1'b0;
		hold_req  = 80;
		repeat (60) send_random_beat();
	endtask

	// sender waits for every result between short bursts
	task automatic test_drain_pause();
		gaps_on   = 1'b1;
		stalls_on = 1'b1;
		repeat (4) begin
			repeat (20) send_random_beat();
			wait_results_done();
		end
	endtask

	// idling switched on and off in stretches
	task automatic test_random_mixed();
		repeat (4) begin
			gaps_on   = 1'($urandom_range(0, 1));
			stalls_on = 1'($urandom_range(0, 1));
			repeat (25) send_random_beat();
		end
	endtask

	initial begin
		arst_n    <= 1'b0;
		cmd_valid <= 1'b0;
		command   <= CMD_TICK;
		slot      <= '0;
		period    <= '0;
		sub_count <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reads_and_unused();
		test_slot_expiry();
		test_random_idling(300);
		test_random_streaming(150);
		test_backpressure();
		test_drain_pause();
		test_random_mixed();

		wait_results_done();
		repeat (10) @(posedge clk);
		if (err_cnt == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
